@@ src/flfa_pkg.sv @@
// Shared types and codes for the free-list fit allocator.
package flfa_pkg;

    localparam int START_W  = 16;
    localparam int AMOUNT_W = 16;
    localparam int INDEX_W  = 4;
    localparam int LEFT_W   = 5;
    localparam int STATUS_W = 2;
    localparam int POLICY_W = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [START_W-1:0]  start_address;
        logic [AMOUNT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  region_index;
        logic [START_W-1:0]  granted_address;
        logic [LEFT_W-1:0]   regions_left;
    } out_item_t;

    typedef struct packed {
        logic rotate;
        logic load;
        logic apply;
        logic remove;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_POST
    } state_t;

endpackage

@@ src/flfa_cell.sv @@
// One region cell of the free list: holds a start and a size, shifts from its neighbor.
module flfa_cell #(
    parameter int IDX_W     = 4,
    parameter int ADDR_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                      aclk,
    input  flfa_pkg::cell_ctl_t       ctl,
    input  logic [IDX_W-1:0]          pos,
    input  logic [ADDR_BITS-1:0]      wr_start,
    input  logic [flfa_pkg::AMOUNT_W-1:0] wr_size,
    input  logic [ADDR_BITS-1:0]      nxt_start,
    input  logic [flfa_pkg::AMOUNT_W-1:0] nxt_size,
    output logic [ADDR_BITS-1:0]      start_q,
    output logic [flfa_pkg::AMOUNT_W-1:0] size_q
);
    import flfa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ADDR_BITS-1:0] start_reg;
    logic [AMOUNT_W-1:0]  size_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rotate) begin
            start_reg <= nxt_start;
            size_reg  <= nxt_size;
        end else if (ctl.load && pos == MY_IDX) begin
            start_reg <= wr_start;
            size_reg  <= wr_size;
        end else if (ctl.apply) begin
            if (pos == MY_IDX) begin
                if (ctl.remove) begin
                    start_reg <= nxt_start;
                    size_reg  <= nxt_size;
                end else begin
                    start_reg <= wr_start;
                    size_reg  <= wr_size;
                end
            end else if (MY_IDX > pos && ctl.remove) begin
                start_reg <= nxt_start;
                size_reg  <= nxt_size;
            end
        end
    end

    assign start_q = start_reg;
    assign size_q  = size_reg;

endmodule

@@ src/flfa_ctrl.sv @@
// Sequencer: handshakes, policy scan at the head of the ring, update and result staging.
module flfa_ctrl #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  flfa_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output flfa_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flfa_pkg::POLICY_W-1:0]     cfg_data,
    input  logic [ADDR_BITS-1:0]              head_start,
    input  logic [flfa_pkg::AMOUNT_W-1:0]     head_size,
    output flfa_pkg::cell_ctl_t               ctl,
    output logic [$clog2(MAX_REGIONS)-1:0]    pos,
    output logic [ADDR_BITS-1:0]              wr_start,
    output logic [flfa_pkg::AMOUNT_W-1:0]     wr_size
);
    import flfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [IDX_W-1:0] LAST_K = IDX_W'(MAX_REGIONS - 1);
    localparam logic [CNT_W-1:0] FULL   = CNT_W'(MAX_REGIONS);

    state_t               state_reg, state_next;
    logic [POLICY_W-1:0]  policy_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     last_pick_reg, last_pick_next;
    logic [AMOUNT_W-1:0]  req_reg, req_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic                 found_reg, found_next;
    logic                 cand_hi_reg, cand_hi_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [ADDR_BITS-1:0] pick_start_reg, pick_start_next;
    logic [AMOUNT_W-1:0]  pick_size_reg, pick_size_next;
    out_item_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    logic                 s_fire;
    logic                 out_free;
    logic                 hit;
    logic                 k_hi;
    logic                 take;
    logic                 removing;
    logic [31:0]          start_ext;
    logic [31:0]          grant_ext;
    logic [31:0]          pick_ext;
    logic [31:0]          count_ext;
    logic [31:0]          count_dec_ext;
    logic [31:0]          count_inc_ext;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign start_ext     = 32'(s_data.start_address);
    assign grant_ext     = 32'(pick_start_reg);
    assign pick_ext      = 32'(pick_reg);
    assign count_ext     = 32'(count_reg);
    assign count_dec_ext = 32'(count_reg - CNT_W'(1));
    assign count_inc_ext = 32'(count_reg + CNT_W'(1));

    assign hit      = (CNT_W'(k_reg) < count_reg) && (head_size >= req_reg);
    assign k_hi     = (k_reg > last_pick_reg);
    assign removing = (pick_size_reg == req_reg);

    always_comb begin
        case (policy_reg)
            POL_FIRST: take = hit && !found_reg;
            POL_BEST:  take = hit && (!found_reg || head_size < pick_size_reg);
            POL_WORST: take = hit && (!found_reg || head_size > pick_size_reg);
            POL_NEXT:  take = hit && (!found_reg || (!cand_hi_reg && k_hi));
            default:   take = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_data.cmd == CMD_ALLOC && s_data.amount != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_POST;
                    end
                end
            end
            S_SCAN: begin
                if (k_reg == LAST_K) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: state_next = S_POST;
            S_POST: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl             = '0;
        pos             = '0;
        wr_start        = '0;
        wr_size         = '0;
        count_next      = count_reg;
        last_pick_next  = last_pick_reg;
        req_next        = req_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        cand_hi_next    = cand_hi_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        pick_size_next  = pick_size_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_next.status          = ST_REJECT;
                    res_next.region_index    = '0;
                    res_next.granted_address = '0;
                    res_next.regions_left    = count_ext[LEFT_W-1:0];
                    req_next                 = s_data.amount;
                    k_next                   = '0;
                    found_next               = 1'b0;
                    cand_hi_next             = 1'b0;
                    if (s_data.cmd == CMD_LOAD) begin
                        if (count_reg < FULL && s_data.amount != '0) begin
                            ctl.load               = 1'b1;
                            pos                    = count_reg[IDX_W-1:0];
                            wr_start               = start_ext[ADDR_BITS-1:0];
                            wr_size                = s_data.amount;
                            count_next             = count_reg + CNT_W'(1);
                            res_next.status        = ST_LOADED;
                            res_next.region_index  = count_ext[INDEX_W-1:0];
                            res_next.regions_left  = count_inc_ext[LEFT_W-1:0];
                        end
                    end
                end
            end
            S_SCAN: begin
                ctl.rotate = 1'b1;
                k_next     = k_reg + IDX_W'(1);
                if (take) begin
                    found_next      = 1'b1;
                    cand_hi_next    = k_hi;
                    pick_next       = k_reg;
                    pick_start_next = head_start;
                    pick_size_next  = head_size;
                end
            end
            S_APPLY: begin
                res_next.status          = ST_NOFIT;
                res_next.region_index    = '0;
                res_next.granted_address = '0;
                res_next.regions_left    = count_ext[LEFT_W-1:0];
                if (found_reg) begin
                    ctl.apply  = 1'b1;
                    ctl.remove = removing;
                    pos        = pick_reg;
                    wr_start   = pick_start_reg + ADDR_BITS'(req_reg);
                    wr_size    = pick_size_reg - req_reg;
                    res_next.status          = ST_ALLOC;
                    res_next.region_index    = pick_ext[INDEX_W-1:0];
                    res_next.granted_address = grant_ext[START_W-1:0];
                    if (removing) begin
                        count_next            = count_reg - CNT_W'(1);
                        res_next.regions_left = count_dec_ext[LEFT_W-1:0];
                    end
                    if (policy_reg == POL_NEXT) begin
                        last_pick_next = pick_reg;
                    end
                end
            end
            S_POST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_FIRST;
            count_reg     <= '0;
            last_pick_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_pick_reg <= last_pick_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        cand_hi_reg    <= cand_hi_next;
        pick_reg       <= pick_next;
        pick_start_reg <= pick_start_next;
        pick_size_reg  <= pick_size_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

endmodule

@@ src/free_list_fit_allocator_top.sv @@
// Top level of the free-list fit allocator: ring of region cells and its sequencer.
//
// The free list lives in a ring of MAX_REGIONS cells. A load, or any rejected
// command, passes from input transfer through the result register to the
// output register. An allocate first rotates the whole ring once past the
// head cell, where the fit policy is evaluated one region per cycle, then
// updates or removes the chosen region with a one-step shift of the cells
// above it, and hands the result to the output register once it is free. A new
// input is taken once the previous result sits in the output register, even
// while it waits for its transfer. No clearing pass after reset.
module free_list_fit_allocator_top #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  flfa_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output flfa_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flfa_pkg::POLICY_W-1:0] cfg_data
);
    import flfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);

    cell_ctl_t            ctl;
    logic [IDX_W-1:0]     pos;
    logic [ADDR_BITS-1:0] wr_start;
    logic [AMOUNT_W-1:0]  wr_size;
    logic [ADDR_BITS-1:0] cell_start [MAX_REGIONS];
    logic [AMOUNT_W-1:0]  cell_size  [MAX_REGIONS];

    flfa_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_start (cell_start[0]),
        .head_size  (cell_size[0]),
        .ctl        (ctl),
        .pos        (pos),
        .wr_start   (wr_start),
        .wr_size    (wr_size)
    );

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        flfa_cell #(
            .IDX_W     (IDX_W),
            .ADDR_BITS (ADDR_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .pos       (pos),
            .wr_start  (wr_start),
            .wr_size   (wr_size),
            .nxt_start (cell_start[(i + 1) % MAX_REGIONS]),
            .nxt_size  (cell_size[(i + 1) % MAX_REGIONS]),
            .start_q   (cell_start[i]),
            .size_q    (cell_size[i])
        );
    end

endmodule
